### hdl/packed_pixel_window_store_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packed pixel window store
// Shared assertion forms, all clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef PACKED_PIXEL_WINDOW_STORE_UNIT_DEFINES_SVH
`define PACKED_PIXEL_WINDOW_STORE_UNIT_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle
`define PPWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle
`define PPWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ppws_pkg.sv
// ---------------------------------------------------------------------------
// ppws_pkg
// Shared constants, queue entry type and depth helpers for the pixel store.
// ---------------------------------------------------------------------------
package ppws_pkg;

  // Geometry of the store
  localparam int COORD_BITS   = 12;
  localparam int BUFFER_BYTES = 65536;
  localparam int ADDR_BITS    = $clog2(BUFFER_BYTES);

  // Field widths
  localparam int DEPTH_BITS   = 3;
  localparam int VALUE_BITS   = 32;
  localparam int STATUS_BITS  = 2;
  localparam int LANE_BITS    = 2;
  localparam int SHIFT_BITS   = 3;

  // Index arithmetic widths
  localparam int BF_BITS      = COORD_BITS + 2;
  localparam int ROW_BITS     = COORD_BITS + 3;
  localparam int PROD_BITS    = ROW_BITS + COORD_BITS;
  localparam int IDX_BITS     = (PROD_BITS + 1 > ADDR_BITS + 1) ? PROD_BITS + 1 : ADDR_BITS + 1;

  // Stream widths, rounded up to whole bytes
  localparam int S_TDATA_BITS = ((2 * COORD_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((VALUE_BITS + STATUS_BITS + 7) / 8) * 8;
  localparam int M_PAD_BITS   = M_TDATA_BITS - VALUE_BITS - STATUS_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (COORD_BITS > DEPTH_BITS) ? COORD_BITS : DEPTH_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM = 3'd4;

  // Depth codes
  localparam logic [DEPTH_BITS-1:0] DEPTH_1  = 3'd0;
  localparam logic [DEPTH_BITS-1:0] DEPTH_2  = 3'd1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_4  = 3'd2;
  localparam logic [DEPTH_BITS-1:0] DEPTH_8  = 3'd3;
  localparam logic [DEPTH_BITS-1:0] DEPTH_16 = 3'd4;
  localparam logic [DEPTH_BITS-1:0] DEPTH_24 = 3'd5;
  localparam logic [DEPTH_BITS-1:0] DEPTH_32 = 3'd6;

  // Commands and status codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BEYOND  = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // One classified access, ready for the memory side
  typedef struct packed {
    logic                   write;
    logic [STATUS_BITS-1:0] status;
    logic [ADDR_BITS-1:0]   addr;
    logic [LANE_BITS-1:0]   last_lane;
    logic                   sub;
    logic [SHIFT_BITS-1:0]  shift;
    logic [7:0]             mask;
    logic [VALUE_BITS-1:0]  value;
  } ppws_entry_t;

  // floor(x * bpp / 8) for the given depth code
  function automatic logic [BF_BITS-1:0] byte_floor(input logic [COORD_BITS-1:0] x,
                                                    input logic [DEPTH_BITS-1:0] code);
    logic [BF_BITS-1:0] xe;
    xe = BF_BITS'(x);
    unique case (code)
      DEPTH_1:  byte_floor = xe >> 3;
      DEPTH_2:  byte_floor = xe >> 2;
      DEPTH_4:  byte_floor = xe >> 1;
      DEPTH_8:  byte_floor = xe;
      DEPTH_16: byte_floor = xe << 1;
      DEPTH_24: byte_floor = (xe << 1) + xe;
      default:  byte_floor = xe << 2;
    endcase
  endfunction

  // Bytes per pixel minus one
  function automatic logic [LANE_BITS-1:0] last_lane_of(input logic [DEPTH_BITS-1:0] code);
    unique case (code)
      DEPTH_16: last_lane_of = 2'd1;
      DEPTH_24: last_lane_of = 2'd2;
      DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8: last_lane_of = 2'd0;
      default:  last_lane_of = 2'd3;
    endcase
  endfunction

  // Bit position of a sub-byte pixel, packed MSB first
  function automatic logic [SHIFT_BITS-1:0] sub_shift(input logic [2:0] xl,
                                                      input logic [DEPTH_BITS-1:0] code);
    unique case (code)
      DEPTH_1: sub_shift = 3'd7 - xl;
      DEPTH_2: sub_shift = {2'd3 - xl[1:0], 1'b0};
      DEPTH_4: sub_shift = xl[0] ? 3'd0 : 3'd4;
      default: sub_shift = 3'd0;
    endcase
  endfunction

  // Value mask of a sub-byte pixel
  function automatic logic [7:0] sub_mask(input logic [DEPTH_BITS-1:0] code);
    unique case (code)
      DEPTH_1: sub_mask = 8'h01;
      DEPTH_2: sub_mask = 8'h03;
      DEPTH_4: sub_mask = 8'h0F;
      default: sub_mask = 8'hFF;
    endcase
  endfunction

endpackage

### hdl/packed_pixel_window_store_unit.sv
// ---------------------------------------------------------------------------
// packed_pixel_window_store_unit
// Reads or writes one pixel of a packed bitmap window per transfer. The
// front end takes a transfer every cycle while its queue has room and
// classifies it in a pipeline (window check, row product, byte index and
// buffer check). The back end then works through the single byte-wide port
// of the pixel memory, one byte per cycle: a rejected access goes straight
// to the result, a write stores its bytes in turn, a read fetches its bytes
// and then a tail step, and a sub-byte write (read-modify-write) reads the
// byte and writes the merged byte back in the tail step. A new access is
// taken only once the last is done. The result waits in an output register,
// so the next access proceeds while it is unclaimed.
// The pixel memory is not cleared by reset; read only bytes written before.
// ---------------------------------------------------------------------------
module packed_pixel_window_store_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_coord, y_coord, pixel_value (lowest bits first)
  input  logic [ppws_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_value, access_status (lowest bits first)
  output logic [ppws_pkg::M_TDATA_BITS-1:0]   m_axis_tdata
);
  import ppws_pkg::*;

  logic        push;
  ppws_entry_t push_entry;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  ppws_entry_t head;

  // Accept and classify
  ppws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (queue_full)
  );

  // Decouple front from memory side
  ppws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Access the pixel memory
  ppws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### hdl/ppws_front.sv
// ---------------------------------------------------------------------------
// ppws_front
// Holds the configuration, accepts accesses and classifies them in three
// stages: window check, row offset product, byte index and buffer check.
// ---------------------------------------------------------------------------
module ppws_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_coord, y_coord, pixel_value (lowest bits first)
  input  logic [ppws_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  output logic                                push,
  output ppws_pkg::ppws_entry_t               push_entry,
  input  logic                                queue_full
);
  import ppws_pkg::*;

  // Configuration registers
  logic [DEPTH_BITS-1:0] depth_code;
  logic [COORD_BITS-1:0] window_left;
  logic [COORD_BITS-1:0] window_top;
  logic [COORD_BITS-1:0] window_right;
  logic [COORD_BITS-1:0] window_bottom;

  // Input fields
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  logic [VALUE_BITS-1:0] pixel_value;

  // Stage one results
  logic                  outside;
  logic [BF_BITS-1:0]    bf_x;
  logic [BF_BITS-1:0]    bf_left;
  logic [BF_BITS-1:0]    bf_right;
  logic [LANE_BITS-1:0]  last_lane;

  // Pipeline registers
  logic                   v1, v2, v3;
  logic                   s1_write, s2_write;
  logic                   s1_outside, s2_outside;
  logic [BF_BITS-1:0]     s1_dx, s2_dx;
  logic [ROW_BITS-1:0]    s1_row;
  logic [COORD_BITS-1:0]  s1_dy;
  logic [PROD_BITS-1:0]   s2_prod;
  logic [LANE_BITS-1:0]   s1_lane, s2_lane;
  logic                   s1_sub, s2_sub;
  logic [SHIFT_BITS-1:0]  s1_shift, s2_shift;
  logic [7:0]             s1_mask, s2_mask;
  logic [VALUE_BITS-1:0]  s1_value, s2_value;

  logic                   move;
  logic [IDX_BITS-1:0]    idx;
  logic [IDX_BITS-1:0]    idx_end;
  ppws_entry_t            entry_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code    <= DEPTH_8;
      window_left   <= '0;
      window_top    <= '0;
      window_right  <= '0;
      window_bottom <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH:  depth_code    <= cfg_data[DEPTH_BITS-1:0];
        REG_LEFT:   window_left   <= cfg_data[COORD_BITS-1:0];
        REG_TOP:    window_top    <= cfg_data[COORD_BITS-1:0];
        REG_RIGHT:  window_right  <= cfg_data[COORD_BITS-1:0];
        REG_BOTTOM: window_bottom <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the transfer
  assign x_coord     = s_axis_tdata[COORD_BITS-1:0];
  assign y_coord     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pixel_value = s_axis_tdata[2*COORD_BITS+VALUE_BITS-1:2*COORD_BITS];

  // Classify against the window and form the byte offsets
  assign outside   = (x_coord < window_left) || (x_coord > window_right) ||
                     (y_coord < window_top)  || (y_coord > window_bottom);
  assign bf_x      = byte_floor(x_coord, depth_code);
  assign bf_left   = byte_floor(window_left, depth_code);
  assign bf_right  = byte_floor(window_right, depth_code);
  assign last_lane = last_lane_of(depth_code);

  // Advance the whole pipe unless the last stage is stuck on a full queue
  assign push          = v3 && !queue_full;
  assign move          = !v3 || !queue_full;
  assign s_axis_tready = move;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (move) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Final index and buffer bounds check
  assign idx     = IDX_BITS'(s2_dx) + IDX_BITS'(s2_prod);
  assign idx_end = idx + IDX_BITS'(s2_lane);

  always_comb begin
    entry_next.write     = s2_write;
    entry_next.addr      = idx[ADDR_BITS-1:0];
    entry_next.last_lane = s2_lane;
    entry_next.sub       = s2_sub;
    entry_next.shift     = s2_shift;
    entry_next.mask      = s2_mask;
    entry_next.value     = s2_value;
    priority if (s2_outside) begin
      entry_next.status = ST_OUTSIDE;
    end else if (idx_end >= IDX_BITS'(BUFFER_BYTES)) begin
      entry_next.status = ST_BEYOND;
    end else begin
      entry_next.status = ST_DONE;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (move) begin
      s1_write   <= (s_axis_tuser == CMD_WRITE);
      s1_outside <= outside;
      s1_dx      <= bf_x - bf_left;
      s1_row     <= ROW_BITS'(bf_right) - ROW_BITS'(bf_left) + ROW_BITS'(last_lane) +
                    ROW_BITS'(1);
      s1_dy      <= y_coord - window_top;
      s1_lane    <= last_lane;
      s1_sub     <= (depth_code == DEPTH_1) || (depth_code == DEPTH_2) ||
                    (depth_code == DEPTH_4);
      s1_shift   <= sub_shift(x_coord[2:0], depth_code);
      s1_mask    <= sub_mask(depth_code);
      s1_value   <= pixel_value;

      s2_write   <= s1_write;
      s2_outside <= s1_outside;
      s2_dx      <= s1_dx;
      s2_prod    <= PROD_BITS'(s1_row) * PROD_BITS'(s1_dy);
      s2_lane    <= s1_lane;
      s2_sub     <= s1_sub;
      s2_shift   <= s1_shift;
      s2_mask    <= s1_mask;
      s2_value   <= s1_value;

      push_entry <= entry_next;
    end
  end

endmodule

### hdl/ppws_queue.sv
// ---------------------------------------------------------------------------
// ppws_queue
// Short FIFO of classified accesses between the front and the back.
// ---------------------------------------------------------------------------
module ppws_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ppws_pkg::ppws_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output ppws_pkg::ppws_entry_t head
);
  import ppws_pkg::*;

  ppws_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
    bump = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### hdl/ppws_back.sv
// ---------------------------------------------------------------------------
// ppws_back
// Carries out one access against the byte-wide pixel memory, one byte per
// cycle, and holds the result in an output register.
// ---------------------------------------------------------------------------
module ppws_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  ppws_pkg::ppws_entry_t             head,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_value, access_status (lowest bits first)
  output logic [ppws_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);
  import ppws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [7:0]             mem [BUFFER_BYTES];
  logic [7:0]             rdata;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_addr;
  logic [7:0]             mem_wdata;

  logic [2:0]             state;
  ppws_entry_t            cur;
  logic [LANE_BITS-1:0]   cnt;
  logic [LANE_BITS-1:0]   lane_prev;
  logic [VALUE_BITS-1:0]  acc;
  logic                   out_valid;
  logic                   out_free;
  logic [VALUE_BITS-1:0]  out_value;
  logic [STATUS_BITS-1:0] out_status;
  logic [7:0]             mask_sh;
  logic [7:0]             merged;

  assign pop       = (state == S_IDLE) && head_valid;
  assign out_free  = !out_valid || m_axis_tready;
  assign lane_prev = cnt - LANE_BITS'(1);
  assign mask_sh   = cur.mask << cur.shift;
  assign merged    = (rdata & ~mask_sh) | ((cur.value[7:0] & cur.mask) << cur.shift);

  // Memory port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur.addr + ADDR_BITS'(cnt);
    mem_wdata = cur.value[{cnt, 3'b000} +: 8];
    if (state == S_WR) begin
      mem_we = 1'b1;
    end else if ((state == S_TAIL) && cur.sub && cur.write) begin
      mem_we    = 1'b1;
      mem_wdata = merged;
    end
  end

  // Pixel memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Sequencer and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            priority if (head.status != ST_DONE) begin
              state <= S_DONE;
            end else if (head.write && !head.sub) begin
              state <= S_WR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_WR: begin
          if (cnt == cur.last_lane) begin
            state <= S_DONE;
          end
        end
        S_RD: begin
          if (cnt == cur.last_lane) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers: byte counter, read accumulator, result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cnt <= '0;
      acc <= '0;
    end
    if ((state == S_WR) || (state == S_RD)) begin
      if (cnt != cur.last_lane) begin
        cnt <= cnt + LANE_BITS'(1);
      end
    end
    if ((state == S_RD) && (cnt != '0)) begin
      acc[{lane_prev, 3'b000} +: 8] <= rdata;
    end
    if (state == S_TAIL) begin
      if (cur.sub) begin
        if (!cur.write) begin
          acc <= VALUE_BITS'((rdata >> cur.shift) & cur.mask);
        end
      end else begin
        acc[{cnt, 3'b000} +: 8] <= rdata;
      end
    end
    if ((state == S_DONE) && out_free) begin
      out_value  <= cur.write ? '0 : acc;
      out_status <= cur.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {M_PAD_BITS'(0), out_status, out_value};

endmodule

### hdl/ppws_checker.sv
// ---------------------------------------------------------------------------
// ppws_checker
// Port-level checks of the pixel store, bound to the top level.
// ---------------------------------------------------------------------------
`include "packed_pixel_window_store_unit_defines.svh"

module ppws_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_we,
  input logic [ppws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [ppws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [ppws_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ppws_pkg::M_TDATA_BITS-1:0]   m_axis_tdata
);
  import ppws_pkg::*;

  logic                   in_xfer;
  logic                   out_xfer;
  logic [3:0]             pending;
  logic [STATUS_BITS-1:0] status;
  logic [VALUE_BITS-1:0]  value;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign status   = m_axis_tdata[VALUE_BITS+STATUS_BITS-1:VALUE_BITS];
  assign value    = m_axis_tdata[VALUE_BITS-1:0];

  // Track accesses taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 4'd1;
    end
  end

  `PPWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `PPWS_ASSERT_NOW(a_no_phantom, out_xfer, pending != 4'd0, "result without a pending access")
  `PPWS_ASSERT_NOW(a_status_code, m_axis_tvalid, status == ST_DONE || status == ST_OUTSIDE || status == ST_BEYOND, "unknown access status")
  `PPWS_ASSERT_NOW(a_reject_zero, m_axis_tvalid && (status != ST_DONE), value == '0, "rejected access returned data")

endmodule

bind packed_pixel_window_store_unit ppws_checker u_ppws_checker (.*);

### tb/sv/ppws_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ppws_result_checker
// Follows the configuration port and both stream channels of the pixel
// store, keeps its own byte copy of the pixel memory, works out the result
// of every accepted access and compares each returned result, field by
// field, with the oldest one still waiting.
// ---------------------------------------------------------------------------
module ppws_result_checker
  import ppws_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // x_coord, y_coord, pixel_value (lowest bits first)
  input  logic [S_TDATA_BITS-1:0]   s_axis_tdata,
  // command
  input  logic                      s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // read_value, access_status (lowest bits first)
  input  logic [M_TDATA_BITS-1:0]   m_axis_tdata,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [VALUE_BITS-1:0]  read_value;
    logic [STATUS_BITS-1:0] access_status;
  } pixel_result_t;

  // Byte copy of the pixel memory and of the window registers
  bit   [7:0]            pixel_mem [BUFFER_BYTES];
  logic [DEPTH_BITS-1:0] depth_code;
  logic [COORD_BITS-1:0] win_left, win_top, win_right, win_bottom;
  pixel_result_t         pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("%0t MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  function automatic int bits_per_pixel(input logic [DEPTH_BITS-1:0] code);
    case (code)
      DEPTH_1:  return 1;
      DEPTH_2:  return 2;
      DEPTH_4:  return 4;
      DEPTH_8:  return 8;
      DEPTH_16: return 16;
      DEPTH_24: return 24;
      default:  return 32;
    endcase
  endfunction

  // Apply one pixel access to the memory copy and return what it yields
  function automatic pixel_result_t access_pixel(input logic                  cmd,
                                                 input logic [COORD_BITS-1:0] x,
                                                 input logic [COORD_BITS-1:0] y,
                                                 input logic [VALUE_BITS-1:0] value);
    pixel_result_t res;
    int            bpp, nbytes, per_byte, shift, k;
    longint        left_byte, row_bytes, idx;
    logic [7:0]    mask;
    res    = '0;
    bpp    = bits_per_pixel(depth_code);
    nbytes = (bpp + 7) / 8;
    if (x < win_left || x > win_right || y < win_top || y > win_bottom) begin
      res.access_status = ST_OUTSIDE;
      return res;
    end
    left_byte = (longint'(win_left) * bpp) >> 3;
    row_bytes = ((longint'(win_right) * bpp) >> 3) - left_byte + nbytes;
    idx = ((longint'(x) * bpp) >> 3) - left_byte
          + row_bytes * (longint'(y) - longint'(win_top));
    if (idx + nbytes - 1 >= BUFFER_BYTES) begin
      res.access_status = ST_BEYOND;
      return res;
    end
    res.access_status = ST_DONE;
    if (bpp < 8) begin
      // Sub-byte pixel, leftmost pixel in the high bits
      per_byte = 8 / bpp;
      shift    = bpp * (per_byte - int'(x) % per_byte - 1);
      mask     = 8'((1 << bpp) - 1);
      if (cmd == CMD_WRITE) begin
        pixel_mem[idx] = (pixel_mem[idx] & ~(mask << shift)) | ((value[7:0] & mask) << shift);
      end else begin
        res.read_value = VALUE_BITS'((pixel_mem[idx] >> shift) & mask);
      end
    end else begin
      // Whole bytes, lowest byte first
      for (k = 0; k < nbytes; k++) begin
        if (cmd == CMD_WRITE) begin
          pixel_mem[idx + k] = value[8*k +: 8];
        end else begin
          res.read_value[8*k +: 8] = pixel_mem[idx + k];
        end
      end
    end
    return res;
  endfunction

  // Track registers, retire results, then queue the new access
  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst) begin
      depth_code = DEPTH_8;
      win_left   = '0;
      win_top    = '0;
      win_right  = '0;
      win_bottom = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH:  depth_code = cfg_data[DEPTH_BITS-1:0];
          REG_LEFT:   win_left   = cfg_data[COORD_BITS-1:0];
          REG_TOP:    win_top    = cfg_data[COORD_BITS-1:0];
          REG_RIGHT:  win_right  = cfg_data[COORD_BITS-1:0];
          REG_BOTTOM: win_bottom = cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_value    = m_axis_tdata[VALUE_BITS-1:0];
        got.access_status = m_axis_tdata[VALUE_BITS +: STATUS_BITS];
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result %h/%0d with no access pending",
                                  got.read_value, got.access_status));
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value) begin
            flag_mismatch($sformatf("read_value %h, expected %h",
                                    got.read_value, want.read_value));
          end
          if (got.access_status !== want.access_status) begin
            flag_mismatch($sformatf("access_status %0d, expected %0d",
                                    got.access_status, want.access_status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(access_pixel(s_axis_tuser,
                                               s_axis_tdata[COORD_BITS-1:0],
                                               s_axis_tdata[COORD_BITS +: COORD_BITS],
                                               s_axis_tdata[2*COORD_BITS +: VALUE_BITS]));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### tb/sv/tb_packed_pixel_window_store_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_packed_pixel_window_store_unit
// Drives pixel reads and writes into the window store under a series of
// window and depth settings: a directed set over the corner cases, then
// random phases built mostly of writes followed by reads of the same pixels.
// Reads only touch bytes written earlier. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module tb_packed_pixel_window_store_unit;
  import ppws_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_SPARE = 3'd7;  // spare code, acts as 32 bits
  localparam logic [COORD_BITS-1:0] COORD_MAX   = '1;
  localparam int PREFILL_BYTES = 256;
  localparam int TOTAL_ITEMS   = 1250;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_PHASES    = 60;

  logic                      clk;
  logic                      rst           = 1'b1;
  logic                      cfg_we        = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // x_coord, y_coord, pixel_value (lowest bits first)
  logic [S_TDATA_BITS-1:0]   s_axis_tdata  = '0;
  // command
  logic                      s_axis_tuser  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // read_value, access_status (lowest bits first)
  logic [M_TDATA_BITS-1:0]   m_axis_tdata;
  int                        mismatches;
  int                        outstanding;

  // Stimulus-side view of the loaded window and of the bytes written so far
  bit                        byte_written [BUFFER_BYTES];
  int                        cur_bpp    = 8;
  logic [COORD_BITS-1:0]     cur_left   = '0;
  logic [COORD_BITS-1:0]     cur_top    = '0;
  logic [COORD_BITS-1:0]     cur_right  = '0;
  logic [COORD_BITS-1:0]     cur_bottom = '0;
  logic [2*COORD_BITS-1:0]   stored_spots [$];
  bit                        steady = 1'b0;
  int                        sent   = 0;

  packed_pixel_window_store_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ppws_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: drop ready at random, with odds of 8 in 100, never while steady
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 8);
  end

  // Byte span and status of a pixel under the loaded window
  function automatic logic [STATUS_BITS-1:0] locate(input  logic [COORD_BITS-1:0] x,
                                                    input  logic [COORD_BITS-1:0] y,
                                                    output int                    first,
                                                    output int                    count);
    longint left_byte, row_bytes, idx;
    count = (cur_bpp + 7) / 8;
    first = 0;
    if (x < cur_left || x > cur_right || y < cur_top || y > cur_bottom) return ST_OUTSIDE;
    left_byte = (longint'(cur_left) * cur_bpp) >> 3;
    row_bytes = ((longint'(cur_right) * cur_bpp) >> 3) - left_byte + count;
    idx = ((longint'(x) * cur_bpp) >> 3) - left_byte
          + row_bytes * (longint'(y) - longint'(cur_top));
    if (idx + count > BUFFER_BYTES) return ST_BEYOND;
    first = int'(idx);
    return ST_DONE;
  endfunction

  // Coordinate in [lo, hi], at most reach above lo; anywhere if the range is empty
  function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] lo,
                                                 input logic [COORD_BITS-1:0] hi,
                                                 input int                    reach);
    int room;
    room = int'(hi) - int'(lo);
    if (room < 0) return COORD_BITS'($urandom);
    if (room > reach) room = reach;
    return lo + COORD_BITS'($urandom_range(room));
  endfunction

  // Issue one pixel access; drop it if it would read a byte never written
  task automatic send_pixel(input logic                  cmd,
                            input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y,
                            input logic [VALUE_BITS-1:0] value);
    int first, count, k;
    bit filled;
    if (locate(x, y, first, count) == ST_DONE) begin
      filled = 1'b1;
      for (k = 0; k < count; k++) filled &= byte_written[first + k];
      // a read, or the read half of a sub-byte update, needs written bytes
      if (!filled && (cmd == CMD_READ || cur_bpp < 8)) return;
      if (cmd == CMD_WRITE) begin
        for (k = 0; k < count; k++) byte_written[first + k] = 1'b1;
        stored_spots.push_back({y, x});
      end
    end
    while (!steady && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= S_TDATA_BITS'({value, y, x});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Wait for the store to drain, then write all five registers
  task automatic load_window(input logic [DEPTH_BITS-1:0] depth,
                             input logic [COORD_BITS-1:0] left,
                             input logic [COORD_BITS-1:0] top,
                             input logic [COORD_BITS-1:0] right,
                             input logic [COORD_BITS-1:0] bottom);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEPTH;
    cfg_data  <= CFG_DATA_BITS'(depth);
    @(negedge clk);
    cfg_index <= REG_LEFT;
    cfg_data  <= left;
    @(negedge clk);
    cfg_index <= REG_TOP;
    cfg_data  <= top;
    @(negedge clk);
    cfg_index <= REG_RIGHT;
    cfg_data  <= right;
    @(negedge clk);
    cfg_index <= REG_BOTTOM;
    cfg_data  <= bottom;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (depth)
      DEPTH_1:  cur_bpp = 1;
      DEPTH_2:  cur_bpp = 2;
      DEPTH_4:  cur_bpp = 4;
      DEPTH_8:  cur_bpp = 8;
      DEPTH_16: cur_bpp = 16;
      DEPTH_24: cur_bpp = 24;
      default:  cur_bpp = 32;
    endcase
    cur_left   = left;
    cur_top    = top;
    cur_right  = right;
    cur_bottom = bottom;
    stored_spots.delete();
  endtask

  // One random setting followed by a burst of accesses
  task automatic random_phase();
    logic [DEPTH_BITS-1:0]   depth;
    logic [COORD_BITS-1:0]   l, t, r, b, x, y;
    logic [2*COORD_BITS-1:0] spot;
    logic                    cmd;
    int                      shape, edge_r, edge_b, tries, start, pick;
    depth = DEPTH_BITS'($urandom_range(7));
    shape = $urandom_range(9);
    l = COORD_BITS'($urandom);
    t = COORD_BITS'($urandom);
    edge_r = int'(l) + $urandom_range(63);
    edge_b = int'(t) + $urandom_range(31);
    if (edge_r > COORD_MAX) edge_r = COORD_MAX;
    if (edge_b > COORD_MAX) edge_b = COORD_MAX;
    r = COORD_BITS'(edge_r);
    b = COORD_BITS'(edge_b);
    if (shape >= 5 && shape < 7) begin
      // full-width band of a few rows
      l = '0;
      r = COORD_BITS'(COORD_MAX);
      edge_b = int'(t) + $urandom_range(15);
      b = COORD_BITS'((edge_b > COORD_MAX) ? COORD_MAX : edge_b);
    end else if (shape >= 7 && shape < 9) begin
      r = COORD_BITS'($urandom);
      b = COORD_BITS'($urandom);
    end else if (shape == 9) begin
      // empty window: right edge left of the left edge
      if (l == '0) l = COORD_BITS'(1);
      r = l - COORD_BITS'(1);
    end
    load_window(depth, l, t, r, b);
    start = sent;
    for (tries = 0; tries < 4 * PHASE_ITEMS && sent - start < PHASE_ITEMS; tries++) begin
      pick = $urandom_range(99);
      cmd  = CMD_WRITE;
      x    = near(l, r, 255);
      y    = near(t, b, 4);
      if (pick >= 40 && pick < 70) begin
        // read back a pixel written in this phase
        cmd = CMD_READ;
        if (stored_spots.size() != 0) begin
          spot = stored_spots[$urandom_range(stored_spots.size() - 1)];
          x = spot[COORD_BITS-1:0];
          y = spot[2*COORD_BITS-1:COORD_BITS];
        end
      end else if (pick >= 70 && pick < 80) begin
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        x   = near(l, r, COORD_MAX);
        y   = near(t, b, COORD_MAX);
      end else if (pick >= 80) begin
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        x   = COORD_BITS'($urandom);
        y   = COORD_BITS'($urandom);
      end
      send_pixel(cmd, x, y, $urandom);
    end
  endtask

  initial begin
    int x, phase;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window: one 8-bit pixel at the origin
    send_pixel(CMD_WRITE, 0, 0, 32'hA5C3_0F81);
    send_pixel(CMD_READ, 0, 0, '0);
    send_pixel(CMD_READ, 1, 0, '0);
    send_pixel(CMD_WRITE, COORD_MAX, COORD_MAX, '1);

    // Fill the low bytes so sub-byte pixels there can be updated and read
    load_window(DEPTH_8, 0, 0, COORD_BITS'(PREFILL_BYTES - 1), 0);
    for (x = 0; x < PREFILL_BYTES; x++) send_pixel(CMD_WRITE, COORD_BITS'(x), 0, $urandom);

    // One bit per pixel over the whole plane; rows from 128 on fall past the store
    load_window(DEPTH_1, 0, 0, COORD_MAX, COORD_MAX);
    send_pixel(CMD_WRITE, 3, 0, 32'h0000_0001);
    send_pixel(CMD_READ, 3, 0, '0);
    send_pixel(CMD_WRITE, 7, 0, 32'hFFFF_FFFE);
    send_pixel(CMD_READ, 7, 0, '0);
    send_pixel(CMD_READ, 0, 128, '0);
    send_pixel(CMD_READ, COORD_MAX, COORD_MAX, '0);

    // Two and four bits per pixel in offset windows
    load_window(DEPTH_2, 8, 2, 40, 9);
    send_pixel(CMD_WRITE, 9, 3, '1);
    send_pixel(CMD_READ, 9, 3, '0);
    send_pixel(CMD_READ, 8, 3, '0);
    send_pixel(CMD_READ, 7, 3, '0);
    send_pixel(CMD_READ, 9, 10, '0);
    load_window(DEPTH_4, 1, 0, 30, 4);
    send_pixel(CMD_WRITE, 2, 1, 32'h0000_005A);
    send_pixel(CMD_READ, 2, 1, '0);
    send_pixel(CMD_READ, 3, 1, '0);

    // Widest pixels: last pixel that fits, then one row past the store
    load_window(DEPTH_32, 0, 0, COORD_MAX, COORD_MAX);
    send_pixel(CMD_WRITE, COORD_MAX, 3, 32'hDEAD_BEEF);
    send_pixel(CMD_READ, COORD_MAX, 3, '0);
    send_pixel(CMD_WRITE, 0, 4, 32'h1234_5678);
    load_window(DEPTH_SPARE, 0, 0, COORD_MAX, COORD_MAX);
    send_pixel(CMD_READ, COORD_MAX, 3, '0);

    // 24 bits at the far corner, then an empty window
    load_window(DEPTH_24, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_pixel(CMD_WRITE, COORD_MAX, COORD_MAX, 32'h7F12_3456);
    send_pixel(CMD_READ, COORD_MAX, COORD_MAX, '0);
    load_window(DEPTH_16, 100, 50, 99, 60);
    send_pixel(CMD_READ, 100, 55, '0);

    // Random phases, two of them with no stalls on either side
    for (phase = 0; phase < MAX_PHASES && sent < TOTAL_ITEMS; phase++) begin
      steady = (phase == 3 || phase == 4);
      random_phase();
    end
    steady = 1'b0;

    // Drain, then let the back end settle before the final check
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ppws_pkg.sv
hdl/ppws_front.sv
hdl/ppws_queue.sv
hdl/ppws_back.sv
hdl/packed_pixel_window_store_unit.sv
hdl/ppws_checker.sv
tb/sv/ppws_result_checker.sv
tb/sv/tb_packed_pixel_window_store_unit.sv
